[sv/sprb_pkg.sv]
// ----------------------------------------------------------------------------
// sprb_pkg
// Shared types, codes and constants of the scanline paced read budget core.
// ----------------------------------------------------------------------------
package sprb_pkg;

  localparam int unsigned LINE_BITS_DEF = 10;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SECT_W     = 16;
  localparam int unsigned FB_W       = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned TRIAL_W    = 16;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TRIAL_W-1:0] TRIAL_RST     = 16'd64;
  localparam logic [THR_W-1:0]   STILL_THR_RST = 8'd2;
  localparam logic [THR_W-1:0]   SPIN_THR_RST  = 8'd3;

  // Shortest vblank line that allows a timed budget.
  localparam int unsigned VBL_MIN = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_BUDGET  = 3'd1,
    CMD_MEASURE = 3'd2,
    CMD_SPIN    = 3'd3,
    CMD_STAT    = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIAL = 2'd0,
    CFG_STILL = 2'd1,
    CFG_SPIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [IDX_W-1:0] {
    STAT_FRAMES0  = 4'd0,
    STAT_FRAMES1  = 4'd1,
    STAT_FLIPS0   = 4'd2,
    STAT_FLIPS1   = 4'd3,
    STAT_SECTORS0 = 4'd4,
    STAT_SECTORS1 = 4'd5,
    STAT_STEPS    = 4'd6,
    STAT_SPINS    = 4'd7,
    STAT_CROSS    = 4'd8,
    STAT_PCOUNT   = 4'd9,
    STAT_SLOT     = 4'd10
  } stat_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_DIV    = 3'd2,
    ST_FINISH = 3'd3,
    ST_PUSH   = 3'd4
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_start;
    logic finish;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_status_t;

endpackage

[sv/sprb_div.sv]
// ----------------------------------------------------------------------------
// sprb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sprb_div #(
  parameter int unsigned W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[sv/sprb_dp.sv]
// ----------------------------------------------------------------------------
// sprb_dp
// Datapath: request capture, pacing state, statistics, divider, result regs.
// ----------------------------------------------------------------------------
module sprb_dp #(
  parameter int unsigned LINE_BITS = sprb_pkg::LINE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sprb_pkg::ctrl_cmd_t               cmd_i,
  output sprb_pkg::dp_status_t              sts_o,
  input  logic                              cfg_we_i,
  input  logic [sprb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sprb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [sprb_pkg::CMD_W-1:0]        command_i,
  input  logic [LINE_BITS-1:0]              scan_line_i,
  input  logic [LINE_BITS-1:0]              vblank_line_i,
  input  logic [sprb_pkg::FB_W-1:0]         framebuffer_i,
  input  logic [sprb_pkg::SECT_W-1:0]       normal_sectors_i,
  input  logic [sprb_pkg::SECT_W-1:0]       max_sectors_i,
  input  logic                              spin_mode_i,
  input  logic [sprb_pkg::CNT_W-1:0]        start_frame_i,
  input  logic [LINE_BITS-1:0]              start_line_i,
  input  logic [sprb_pkg::SECT_W-1:0]       sector_count_i,
  input  logic [sprb_pkg::IDX_W-1:0]        stat_index_i,
  output logic [sprb_pkg::SECT_W-1:0]       budget_o,
  output logic                              spin_detected_o,
  output logic [sprb_pkg::CNT_W-1:0]        stat_value_o
);

  localparam int unsigned FRAME_W = LINE_BITS + 1;
  localparam int unsigned LTV_W   = LINE_BITS + 2;
  localparam int unsigned LEFT_W  = LINE_BITS + 3;
  localparam int unsigned EL_W    = LINE_BITS + 3;
  localparam int unsigned DIV_W   = LINE_BITS + 8;
  localparam int unsigned CNT_W   = sprb_pkg::CNT_W;
  localparam int unsigned SECT_W  = sprb_pkg::SECT_W;
  localparam int unsigned THR_W   = sprb_pkg::THR_W;

  // Captured request.
  logic [sprb_pkg::CMD_W-1:0] cmd_q;
  logic [LINE_BITS-1:0]       line_q, vbi_q, start_line_q;
  logic [sprb_pkg::FB_W-1:0]  fb_q;
  logic [SECT_W-1:0]          normal_q, max_q, sectors_q;
  logic                       spin_mode_q;
  logic [CNT_W-1:0]           start_frame_q;
  logic [sprb_pkg::IDX_W-1:0] stat_idx_q;

  // Configuration.
  logic [sprb_pkg::TRIAL_W-1:0] trial_q;
  logic [THR_W-1:0]             still_thr_q, spin_thr_q;

  // Pacing state and statistics.
  logic [CNT_W-1:0]          fc_q, fc_d;
  logic [LINE_BITS-1:0]      last_line_q, last_line_d;
  logic [sprb_pkg::FB_W-1:0] last_fb_q, last_fb_d;
  logic [CNT_W-1:0]          still_run_q, still_run_d;
  logic [LINE_BITS-1:0]      vbl_q, vbl_d;
  logic [LINE_BITS-1:0]      highest_q, highest_d;
  logic [DIV_W-1:0]          tps_q, tps_d;
  logic [THR_W-1:0]          spin_run_q, spin_run_d;
  logic [CNT_W-1:0]          spin_frame_q, spin_frame_d;
  logic [LINE_BITS-1:0]      spin_pos_q, spin_pos_d;
  logic [CNT_W-1:0]          frames0_q, frames0_d, frames1_q, frames1_d;
  logic [CNT_W-1:0]          flips0_q, flips0_d, flips1_q, flips1_d;
  logic [CNT_W-1:0]          sect0_q, sect0_d, sect1_q, sect1_d;
  logic [CNT_W-1:0]          pfc_q, pfc_d;
  logic                      slot_q, slot_d;
  logic [CNT_W-1:0]          step_q, step_d, spin_step_q, spin_step_d, cross_q, cross_d;

  // Results.
  logic [SECT_W-1:0] res_budget_q, res_budget_d;
  logic              res_spin_q, res_spin_d;
  logic [CNT_W-1:0]  res_stat_q, res_stat_d;
  logic [SECT_W-1:0] out_budget_q;
  logic              out_spin_q;
  logic [CNT_W-1:0]  out_stat_q;

  // Frame geometry.
  logic [FRAME_W-1:0] cap, top, frame;

  // Sample terms.
  logic             s_wrap, s_toggle, s_slot, s_flip, s_clear;
  logic [CNT_W-1:0] s_still_inc, s_pfc_inc;

  // Budget terms.
  logic              still, b_short, b_noest, b_early;
  logic [SECT_W-1:0] normal_eff, max_eff, b_early_val, b_q, b_start, b_final;
  logic [LEFT_W-1:0] left, guard, left_g;
  logic [DIV_W-1:0]  b_dividend;

  // Measure terms.
  logic [CNT_W-1:0] wraps;
  logic             m_bad, m_cross;
  logic [EL_W-1:0]  elapsed;
  logic [DIV_W-1:0] m_dividend, tps_new;

  // Spin terms.
  logic             sp_near, sp_hit;
  logic [THR_W-1:0] sp_run_inc;

  logic [CNT_W-1:0] stat_sel;
  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_dividend, div_divisor, quo;

  function automatic logic [LTV_W-1:0] lines_to_vbl(input logic [LINE_BITS-1:0] line,
                                                    input logic [LINE_BITS-1:0] vbl,
                                                    input logic [FRAME_W-1:0]   frm);
    if (line < vbl) begin
      return LTV_W'(vbl - line);
    end
    return LTV_W'(frm) - LTV_W'(line) + LTV_W'(vbl);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q         <= command_i;
      line_q        <= scan_line_i;
      vbi_q         <= vblank_line_i;
      fb_q          <= framebuffer_i;
      normal_q      <= normal_sectors_i;
      max_q         <= max_sectors_i;
      spin_mode_q   <= spin_mode_i;
      start_frame_q <= start_frame_i;
      start_line_q  <= start_line_i;
      sectors_q     <= sector_count_i;
      stat_idx_q    <= stat_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trial_q     <= sprb_pkg::TRIAL_RST;
      still_thr_q <= sprb_pkg::STILL_THR_RST;
      spin_thr_q  <= sprb_pkg::SPIN_THR_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sprb_pkg::CFG_TRIAL) begin
        trial_q <= cfg_data_i[sprb_pkg::TRIAL_W-1:0];
      end
      if (cfg_index_i == sprb_pkg::CFG_STILL) begin
        still_thr_q <= cfg_data_i[THR_W-1:0];
      end
      if (cfg_index_i == sprb_pkg::CFG_SPIN) begin
        spin_thr_q <= cfg_data_i[THR_W-1:0];
      end
    end
  end

  // Frame length: larger of vblank line and capped highest line, plus one.
  always_comb begin
    cap   = {1'b0, vbl_q} + FRAME_W'(vbl_q >> 3);
    top   = ({1'b0, highest_q} > cap) ? cap : {1'b0, highest_q};
    frame = ((top > {1'b0, vbl_q}) ? top : {1'b0, vbl_q}) + 1'b1;
  end

  always_comb begin
    s_wrap      = line_q < last_line_q;
    s_still_inc = still_run_q + CNT_W'(s_wrap);
    s_pfc_inc   = pfc_q + CNT_W'(s_wrap);
    s_toggle    = s_wrap && (s_pfc_inc == CNT_W'(trial_q));
    s_slot      = slot_q ^ s_toggle;
    s_flip      = fb_q != last_fb_q;
    s_clear     = s_flip && (s_still_inc >= CNT_W'(still_thr_q));
  end

  always_comb begin
    still       = still_run_q >= CNT_W'(still_thr_q);
    normal_eff  = (!still && !slot_q) ? SECT_W'(1) : normal_q;
    max_eff     = still ? max_q : normal_eff;
    b_short     = !still && !spin_mode_q;
    b_noest     = (tps_q == '0) || (vbl_q < LINE_BITS'(sprb_pkg::VBL_MIN)) ||
                  ({1'b0, last_line_q} >= frame);
    b_early     = b_short || b_noest;
    b_early_val = b_short ? normal_eff : (still ? normal_q : '0);
    left        = LEFT_W'(lines_to_vbl(last_line_q, vbl_q, frame)) +
                  (still ? LEFT_W'(frame) : '0);
    guard       = LEFT_W'(frame >> 3);
    left_g      = (left > guard) ? left - guard : '0;
    b_dividend  = DIV_W'({left_g, 4'b0000});
    b_start     = still ? normal_q : '0;
    b_q         = (quo < DIV_W'(max_eff)) ? quo[SECT_W-1:0] : max_eff;
    b_final     = (b_q > b_start) ? b_q : b_start;
  end

  always_comb begin
    wraps      = fc_q - start_frame_q;
    m_bad      = (wraps > CNT_W'(3)) || ((wraps == '0) && (last_line_q < start_line_q)) ||
                 ({1'b0, start_line_q} >= frame);
    elapsed    = EL_W'(wraps[1:0]) * EL_W'(frame) + EL_W'(last_line_q) -
                 EL_W'(start_line_q);
    m_cross    = elapsed >= EL_W'(lines_to_vbl(start_line_q, vbl_q, frame));
    m_dividend = DIV_W'({elapsed, 4'b0000});
    tps_new    = (quo >= tps_q) ? quo : tps_q - ((tps_q - quo) >> 3);
  end

  always_comb begin
    sp_near    = (fc_q == spin_frame_q) &&
                 (({1'b0, last_line_q} == {1'b0, spin_pos_q}) ||
                  ({1'b0, last_line_q} == ({1'b0, spin_pos_q} + 1'b1)));
    sp_run_inc = sp_near ? spin_run_q + 1'b1 : THR_W'(1);
    sp_hit     = sp_run_inc >= spin_thr_q;
  end

  always_comb begin
    unique case (stat_idx_q)
      sprb_pkg::STAT_FRAMES0:  stat_sel = frames0_q;
      sprb_pkg::STAT_FRAMES1:  stat_sel = frames1_q;
      sprb_pkg::STAT_FLIPS0:   stat_sel = flips0_q;
      sprb_pkg::STAT_FLIPS1:   stat_sel = flips1_q;
      sprb_pkg::STAT_SECTORS0: stat_sel = sect0_q;
      sprb_pkg::STAT_SECTORS1: stat_sel = sect1_q;
      sprb_pkg::STAT_STEPS:    stat_sel = step_q;
      sprb_pkg::STAT_SPINS:    stat_sel = spin_step_q;
      sprb_pkg::STAT_CROSS:    stat_sel = cross_q;
      sprb_pkg::STAT_PCOUNT:   stat_sel = pfc_q;
      sprb_pkg::STAT_SLOT:     stat_sel = CNT_W'(slot_q);
      default:                 stat_sel = '0;
    endcase
  end

  always_comb begin
    if (cmd_q == sprb_pkg::CMD_BUDGET) begin
      sts_o.need_div = !b_early;
      div_dividend   = b_dividend;
      div_divisor    = tps_q;
    end else begin
      sts_o.need_div = (cmd_q == sprb_pkg::CMD_MEASURE) && (sectors_q != '0) && !m_bad;
      div_dividend   = m_dividend;
      div_divisor    = DIV_W'(sectors_q);
    end
    sts_o.div_busy = div_busy;
    div_start      = cmd_i.div_start;
  end

  sprb_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_comb begin
    fc_d         = fc_q;
    last_line_d  = last_line_q;
    last_fb_d    = last_fb_q;
    still_run_d  = still_run_q;
    vbl_d        = vbl_q;
    highest_d    = highest_q;
    tps_d        = tps_q;
    spin_run_d   = spin_run_q;
    spin_frame_d = spin_frame_q;
    spin_pos_d   = spin_pos_q;
    frames0_d    = frames0_q;
    frames1_d    = frames1_q;
    flips0_d     = flips0_q;
    flips1_d     = flips1_q;
    sect0_d      = sect0_q;
    sect1_d      = sect1_q;
    pfc_d        = pfc_q;
    slot_d       = slot_q;
    step_d       = step_q;
    spin_step_d  = spin_step_q;
    cross_d      = cross_q;
    res_budget_d = res_budget_q;
    res_spin_d   = res_spin_q;
    res_stat_d   = res_stat_q;

    if (cmd_i.exec) begin
      res_budget_d = '0;
      res_spin_d   = 1'b0;
      res_stat_d   = '0;
      unique case (cmd_q)
        sprb_pkg::CMD_SAMPLE: begin
          if (s_wrap) begin
            fc_d = fc_q + 1'b1;
            if (slot_q) begin
              frames1_d = frames1_q + 1'b1;
            end else begin
              frames0_d = frames0_q + 1'b1;
            end
          end
          still_run_d = s_still_inc;
          pfc_d       = s_toggle ? '0 : s_pfc_inc;
          slot_d      = s_slot;
          if (s_flip) begin
            if (s_clear) begin
              frames0_d   = '0;
              frames1_d   = '0;
              flips1_d    = '0;
              sect0_d     = '0;
              sect1_d     = '0;
              pfc_d       = '0;
              slot_d      = 1'b0;
              step_d      = '0;
              spin_step_d = '0;
              cross_d     = '0;
            end
            last_fb_d   = fb_q;
            still_run_d = '0;
            if (s_clear || !s_slot) begin
              flips0_d = (s_clear ? '0 : flips0_q) + 1'b1;
            end else begin
              flips1_d = flips1_q + 1'b1;
            end
          end
          if (vbi_q != vbl_q) begin
            vbl_d     = vbi_q;
            highest_d = '0;
            tps_d     = '0;
          end
          highest_d   = (line_q > highest_d) ? line_q : highest_d;
          last_line_d = line_q;
        end
        sprb_pkg::CMD_BUDGET: begin
          if (b_early) begin
            res_budget_d = b_early_val;
          end
        end
        sprb_pkg::CMD_MEASURE: begin
          if (sectors_q != '0) begin
            step_d = step_q + 1'b1;
            if (slot_q) begin
              sect1_d = sect1_q + CNT_W'(sectors_q);
            end else begin
              sect0_d = sect0_q + CNT_W'(sectors_q);
            end
            if (spin_mode_q) begin
              spin_step_d = spin_step_q + 1'b1;
            end
            if (!m_bad && m_cross) begin
              cross_d = cross_q + 1'b1;
            end
          end
        end
        sprb_pkg::CMD_SPIN: begin
          spin_run_d   = sp_hit ? '0 : sp_run_inc;
          spin_frame_d = fc_q;
          spin_pos_d   = last_line_q;
          res_spin_d   = sp_hit;
        end
        sprb_pkg::CMD_STAT: begin
          res_stat_d = stat_sel;
        end
        default: begin
        end
      endcase
    end

    // Only budget queries and measure steps reach the divide.
    if (cmd_i.finish) begin
      if (cmd_q == sprb_pkg::CMD_BUDGET) begin
        res_budget_d = b_final;
      end else begin
        tps_d = tps_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q         <= '0;
      last_line_q  <= '0;
      last_fb_q    <= '0;
      still_run_q  <= '0;
      vbl_q        <= '0;
      highest_q    <= '0;
      tps_q        <= '0;
      spin_run_q   <= '0;
      spin_frame_q <= '0;
      spin_pos_q   <= '0;
      frames0_q    <= '0;
      frames1_q    <= '0;
      flips0_q     <= '0;
      flips1_q     <= '0;
      sect0_q      <= '0;
      sect1_q      <= '0;
      pfc_q        <= '0;
      slot_q       <= 1'b0;
      step_q       <= '0;
      spin_step_q  <= '0;
      cross_q      <= '0;
    end else begin
      fc_q         <= fc_d;
      last_line_q  <= last_line_d;
      last_fb_q    <= last_fb_d;
      still_run_q  <= still_run_d;
      vbl_q        <= vbl_d;
      highest_q    <= highest_d;
      tps_q        <= tps_d;
      spin_run_q   <= spin_run_d;
      spin_frame_q <= spin_frame_d;
      spin_pos_q   <= spin_pos_d;
      frames0_q    <= frames0_d;
      frames1_q    <= frames1_d;
      flips0_q     <= flips0_d;
      flips1_q     <= flips1_d;
      sect0_q      <= sect0_d;
      sect1_q      <= sect1_d;
      pfc_q        <= pfc_d;
      slot_q       <= slot_d;
      step_q       <= step_d;
      spin_step_q  <= spin_step_d;
      cross_q      <= cross_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_budget_q <= res_budget_d;
    res_spin_q   <= res_spin_d;
    res_stat_q   <= res_stat_d;
    if (cmd_i.push) begin
      out_budget_q <= res_budget_q;
      out_spin_q   <= res_spin_q;
      out_stat_q   <= res_stat_q;
    end
  end

  assign budget_o        = out_budget_q;
  assign spin_detected_o = out_spin_q;
  assign stat_value_o    = out_stat_q;

endmodule

[sv/sprb_ctrl.sv]
// ----------------------------------------------------------------------------
// sprb_ctrl
// Sequencer: accept a request, execute, wait on the divider, push the result.
// ----------------------------------------------------------------------------
module sprb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sprb_pkg::dp_status_t sts_i,
  output sprb_pkg::ctrl_cmd_t  cmd_o
);

  sprb_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sprb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sprb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = sprb_pkg::ST_EXEC;
        end
      end
      sprb_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = sprb_pkg::ST_DIV;
        end else begin
          state_d = sprb_pkg::ST_PUSH;
        end
      end
      sprb_pkg::ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = sprb_pkg::ST_FINISH;
        end
      end
      sprb_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = sprb_pkg::ST_PUSH;
      end
      sprb_pkg::ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = sprb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sprb_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/scanline_paced_read_budget_core.sv]
// ----------------------------------------------------------------------------
// scanline_paced_read_budget_core
// Scanline-paced sector read budget: frame tracking, budget, timing, stats.
// ----------------------------------------------------------------------------
// Every request (sample, budget query, measure step, spin check, statistic
// read) returns exactly one result, one request in flight at a time. Sample,
// spin, statistic and unknown requests go from acceptance through execute and
// push back to idle; budget queries that need a timed answer and measure steps
// that pass the plausibility check also wait on the restoring divider, which
// retires one quotient bit per cycle over LINE_BITS + 8 bits. The result sits
// in an output register, so the next request is taken and worked on while the
// previous result still waits; it stalls only at the final push. Configuration
// writes are always taken (cfg_ready_o is tied high) and must come only while
// the core is idle; indexes past the last register are dropped. The per-sector
// time estimate is kept in 1/16 scanline units; all counters wrap at 32 bits.
// ----------------------------------------------------------------------------
module scanline_paced_read_budget_core #(
  parameter int unsigned LINE_BITS = sprb_pkg::LINE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sprb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sprb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sprb_pkg::CMD_W-1:0]      command_i,
  input  logic [LINE_BITS-1:0]            scan_line_i,
  input  logic [LINE_BITS-1:0]            vblank_line_i,
  input  logic [sprb_pkg::FB_W-1:0]       framebuffer_i,
  input  logic [sprb_pkg::SECT_W-1:0]     normal_sectors_i,
  input  logic [sprb_pkg::SECT_W-1:0]     max_sectors_i,
  input  logic                            spin_mode_i,
  input  logic [sprb_pkg::CNT_W-1:0]      start_frame_i,
  input  logic [LINE_BITS-1:0]            start_line_i,
  input  logic [sprb_pkg::SECT_W-1:0]     sector_count_i,
  input  logic [sprb_pkg::IDX_W-1:0]      stat_index_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sprb_pkg::SECT_W-1:0]     budget_o,
  output logic                            spin_detected_o,
  output logic [sprb_pkg::CNT_W-1:0]      stat_value_o
);

  sprb_pkg::ctrl_cmd_t  cmd;
  sprb_pkg::dp_status_t sts;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Sequencer: one request at a time, wait on the divider when needed.
  sprb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: pacing state, statistics, divider and result registers.
  sprb_dp #(
    .LINE_BITS (LINE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .scan_line_i      (scan_line_i),
    .vblank_line_i    (vblank_line_i),
    .framebuffer_i    (framebuffer_i),
    .normal_sectors_i (normal_sectors_i),
    .max_sectors_i    (max_sectors_i),
    .spin_mode_i      (spin_mode_i),
    .start_frame_i    (start_frame_i),
    .start_line_i     (start_line_i),
    .sector_count_i   (sector_count_i),
    .stat_index_i     (stat_index_i),
    .budget_o         (budget_o),
    .spin_detected_o  (spin_detected_o),
    .stat_value_o     (stat_value_o)
  );

  // One request in flight: an accepted request blocks the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // No request is taken while the divider runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !in_ready_o)
    else $error("request taken during divide");

  // A push never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // Divider only starts from the execute step, never while already running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (cmd.exec && !sts.div_busy))
    else $error("divider restarted while busy");

endmodule

[bench/sprb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprb_checker
// Watches the configuration, request and result channels of the read budget
// core, predicts each result from its own copy of the state and compares.
// ----------------------------------------------------------------------------
module sprb_checker #(
  parameter int unsigned LINE_BITS = sprb_pkg::LINE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sprb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sprb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [sprb_pkg::CMD_W-1:0]      command_i,
  input  logic [LINE_BITS-1:0]            scan_line_i,
  input  logic [LINE_BITS-1:0]            vblank_line_i,
  input  logic [sprb_pkg::FB_W-1:0]       framebuffer_i,
  input  logic [sprb_pkg::SECT_W-1:0]     normal_sectors_i,
  input  logic [sprb_pkg::SECT_W-1:0]     max_sectors_i,
  input  logic                            spin_mode_i,
  input  logic [sprb_pkg::CNT_W-1:0]      start_frame_i,
  input  logic [LINE_BITS-1:0]            start_line_i,
  input  logic [sprb_pkg::SECT_W-1:0]     sector_count_i,
  input  logic [sprb_pkg::IDX_W-1:0]      stat_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [sprb_pkg::SECT_W-1:0]     budget_i,
  input  logic                            spin_detected_i,
  input  logic [sprb_pkg::CNT_W-1:0]      stat_value_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import sprb_pkg::*;

  typedef struct packed {
    logic [SECT_W-1:0] budget;
    logic              spin_hit;
    logic [CNT_W-1:0]  stat;
  } outcome_t;

  outcome_t outcome_q[$];

  logic [31:0] trial_len, still_thr, spin_thr;
  logic [31:0] frames, prev_line, prev_fb, still_cnt, vbl_seen, top_line, sector_time;
  logic [31:0] spin_cnt, spin_frm, spin_pos;
  logic [31:0] slot_frames[2], slot_flips[2], slot_sectors[2];
  logic [31:0] trial_cnt, steps, spin_steps, crossings;
  logic        slot;

  task automatic clear_stats();
    slot_frames = '{0, 0};
    slot_flips = '{0, 0};
    slot_sectors = '{0, 0};
    trial_cnt = 0;
    slot = 1'b0;
    steps = 0;
    spin_steps = 0;
    crossings = 0;
  endtask

  function automatic logic [31:0] frame_len();
    logic [31:0] cap, top;
    cap = vbl_seen + vbl_seen / 8;
    top = (top_line > cap) ? cap : top_line;
    return ((top > vbl_seen) ? top : vbl_seen) + 32'd1;
  endfunction

  function automatic logic [31:0] lines_left(logic [31:0] line, logic [31:0] flen);
    return (line < vbl_seen) ? vbl_seen - line : flen - line + vbl_seen;
  endfunction

  function automatic logic [SECT_W-1:0] budget_for(logic [31:0] norm, logic [31:0] maxs,
                                                   logic spin);
    logic [31:0] flen, left, guard, start, q, n, m;
    logic [63:0] avail;
    logic        still;
    flen = frame_len();
    still = still_cnt >= still_thr;
    n = norm;
    m = maxs;
    if (!still) begin
      // moving screen: slot zero is held to one sector
      if (!slot) n = 1;
      if (!spin) return n[SECT_W-1:0];
      m = n;
    end
    if (sector_time == 0 || vbl_seen < VBL_MIN || prev_line >= flen)
      return still ? n[SECT_W-1:0] : '0;
    left = lines_left(prev_line, flen) + (still ? flen : 32'd0);
    guard = flen / 8;
    left = (left > guard) ? left - guard : 32'd0;
    start = still ? n : 32'd0;
    avail = ({32'd0, left} * 64'd16) / {32'd0, sector_time};
    q = (avail < {32'd0, m}) ? avail[31:0] : m;
    return (q > start) ? q[SECT_W-1:0] : start[SECT_W-1:0];
  endfunction

  task automatic take_sample(logic [31:0] line, logic [31:0] vbi, logic [31:0] fb);
    if (line < prev_line) begin
      frames++;
      still_cnt++;
      slot_frames[slot]++;
      trial_cnt++;
      if (trial_cnt == trial_len) begin
        trial_cnt = 0;
        slot = ~slot;
      end
    end
    if (fb != prev_fb) begin
      // flip after a still screen starts a fresh set of statistics
      if (still_cnt >= still_thr) clear_stats();
      prev_fb = fb;
      still_cnt = 0;
      slot_flips[slot]++;
    end
    if (vbi != vbl_seen) begin
      vbl_seen = vbi;
      top_line = 0;
      sector_time = 0;
    end
    if (line > top_line) top_line = line;
    prev_line = line;
  endtask

  task automatic take_measure(logic [31:0] sfrm, logic [31:0] sline, logic [31:0] cnt,
                              logic spin);
    logic [31:0] wraps, flen, elapsed, per;
    if (cnt == 0) return;
    steps++;
    slot_sectors[slot] += cnt;
    if (spin) spin_steps++;
    wraps = frames - sfrm;
    flen = frame_len();
    if (wraps > 3 || (wraps == 0 && prev_line < sline) || sline >= flen) return;
    elapsed = wraps * flen + prev_line - sline;
    if (elapsed >= lines_left(sline, flen)) crossings++;
    per = elapsed * 16 / cnt;
    sector_time = (per >= sector_time) ? per : sector_time - (sector_time - per) / 8;
  endtask

  function automatic logic spin_check();
    logic near;
    near = (frames == spin_frm) && ((prev_line - spin_pos) <= 32'd1);
    spin_cnt = near ? spin_cnt + 1 : 32'd1;
    spin_frm = frames;
    spin_pos = prev_line;
    if (spin_cnt < spin_thr) return 1'b0;
    spin_cnt = 0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] stat_for(logic [IDX_W-1:0] idx);
    case (idx)
      STAT_FRAMES0:  return slot_frames[0];
      STAT_FRAMES1:  return slot_frames[1];
      STAT_FLIPS0:   return slot_flips[0];
      STAT_FLIPS1:   return slot_flips[1];
      STAT_SECTORS0: return slot_sectors[0];
      STAT_SECTORS1: return slot_sectors[1];
      STAT_STEPS:    return steps;
      STAT_SPINS:    return spin_steps;
      STAT_CROSS:    return crossings;
      STAT_PCOUNT:   return trial_cnt;
      STAT_SLOT:     return {31'd0, slot};
      default:       return 32'd0;
    endcase
  endfunction

  task automatic predict_request(output outcome_t res);
    res = '0;
    case (command_i)
      CMD_SAMPLE:  take_sample(32'(scan_line_i), 32'(vblank_line_i), framebuffer_i);
      CMD_BUDGET:  res.budget = budget_for(32'(normal_sectors_i), 32'(max_sectors_i),
                                           spin_mode_i);
      CMD_MEASURE: take_measure(start_frame_i, 32'(start_line_i), 32'(sector_count_i),
                                spin_mode_i);
      CMD_SPIN:    res.spin_hit = spin_check();
      CMD_STAT:    res.stat = stat_for(stat_index_i);
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want, got;
    if (!rst_ni) begin
      trial_len = 32'(TRIAL_RST);
      still_thr = 32'(STILL_THR_RST);
      spin_thr = 32'(SPIN_THR_RST);
      frames = 0; prev_line = 0; prev_fb = 0; still_cnt = 0;
      vbl_seen = 0; top_line = 0; sector_time = 0;
      spin_cnt = 0; spin_frm = 0; spin_pos = 0;
      clear_stats();
      outcome_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TRIAL: trial_len = 32'(cfg_data_i);
          CFG_STILL: still_thr = 32'(cfg_data_i[7:0]);
          CFG_SPIN:  spin_thr = 32'(cfg_data_i[7:0]);
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing a new one
      if (out_valid_i && out_ready_i) begin
        got = '{budget_i, spin_detected_i, stat_value_i};
        checked_o++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected: budget %0d spin %0d stat %0d",
                   $time, got.budget, got.spin_hit, got.stat);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got.budget !== want.budget) begin
            $display("%0t: budget expected %0d actual %0d", $time, want.budget, got.budget);
            fail_count_o++;
          end
          if (got.spin_hit !== want.spin_hit) begin
            $display("%0t: spin_detected expected %0d actual %0d", $time, want.spin_hit,
                     got.spin_hit);
            fail_count_o++;
          end
          if (got.stat !== want.stat) begin
            $display("%0t: stat_value expected %0d actual %0d", $time, want.stat, got.stat);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_request(want);
        outcome_q.push_back(want);
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

[bench/scanline_paced_read_budget_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_paced_read_budget_core_test
// Drives sample, budget, measure, spin and statistic requests into the read
// budget core over several register settings, with bursty sending and a
// stalling receiver; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module scanline_paced_read_budget_core_test;
  import sprb_pkg::*;

  localparam int unsigned LB = LINE_BITS_DEF;
  // register index past the last register, dropped by the core
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [LB-1:0]     line;
    logic [LB-1:0]     vbl;
    logic [FB_W-1:0]   fb;
    logic [SECT_W-1:0] norm;
    logic [SECT_W-1:0] maxs;
    logic              spin;
    logic [CNT_W-1:0]  sfrm;
    logic [LB-1:0]     sline;
    logic [SECT_W-1:0] scnt;
    logic [IDX_W-1:0]  sidx;
  } request_t;

  logic                  clk, rst_n;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready, out_valid, out_ready;
  logic [CMD_W-1:0]      command;
  logic [LB-1:0]         scan_line, vblank_line, start_line;
  logic [FB_W-1:0]       framebuffer;
  logic [SECT_W-1:0]     normal_sectors, max_sectors, sector_count, budget;
  logic                  spin_mode, spin_detected;
  logic [CNT_W-1:0]      start_frame, stat_value;
  logic [IDX_W-1:0]      stat_index;
  int                    fail_count, pending, checked;

  // frame counter and line as the core will see them, for well-formed steps
  logic [31:0] trk_frame;
  logic [LB-1:0] trk_line, trk_vbl;
  logic [FB_W-1:0] trk_fb;
  int  cmd_cnt[8];
  int  sent;
  bit  hold_req;

  scanline_paced_read_budget_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .scan_line_i(scan_line), .vblank_line_i(vblank_line),
    .framebuffer_i(framebuffer), .normal_sectors_i(normal_sectors),
    .max_sectors_i(max_sectors), .spin_mode_i(spin_mode), .start_frame_i(start_frame),
    .start_line_i(start_line), .sector_count_i(sector_count), .stat_index_i(stat_index),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .budget_o(budget), .spin_detected_o(spin_detected), .stat_value_o(stat_value)
  );

  sprb_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .scan_line_i(scan_line), .vblank_line_i(vblank_line),
    .framebuffer_i(framebuffer), .normal_sectors_i(normal_sectors),
    .max_sectors_i(max_sectors), .spin_mode_i(spin_mode), .start_frame_i(start_frame),
    .start_line_i(start_line), .sector_count_i(sector_count), .stat_index_i(stat_index),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .budget_i(budget), .spin_detected_i(spin_detected), .stat_value_i(stat_value),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop if the core hangs
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: switch among four stall styles at random; a hold request
  // drops ready for a long stretch so the core backs up into the request side.
  initial begin
    int mode, left, hold;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 150);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) == 1);
          2: out_ready = ($urandom_range(0, 9) != 0);
          default: out_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Drive one request at the falling edge and hold it until taken. Ready only
  // moves at the rising edge, so its value here holds for the next edge.
  task automatic send_request(input request_t r);
    logic taken;
    command = r.cmd; scan_line = r.line; vblank_line = r.vbl; framebuffer = r.fb;
    normal_sectors = r.norm; max_sectors = r.maxs; spin_mode = r.spin;
    start_frame = r.sfrm; start_line = r.sline; sector_count = r.scnt;
    stat_index = r.sidx;
    in_valid = 1'b1;
    do begin
      taken = in_ready;
      @(negedge clk);
    end while (!taken);
    // advance the shadow frame tracking exactly as the core will
    if (r.cmd == CMD_SAMPLE) begin
      if (r.line < trk_line) trk_frame++;
      trk_line = r.line;
    end
    cmd_cnt[r.cmd]++;
    sent++;
  endtask

  task automatic go_idle();
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic taken;
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do begin
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid = 1'b0;
  endtask

  // Wait until every result is back, then let the core settle.
  task automatic drain();
    go_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic request_t blank(input logic [CMD_W-1:0] cmd);
    request_t r;
    r = '{cmd, trk_line, trk_vbl, trk_fb, 16'd0, 16'd0, 1'b0, trk_frame, 10'd0, 16'd0, 4'd0};
    return r;
  endfunction

  // Build a random request: mostly well-formed scanline progress within the
  // current frame, with occasional vblank moves, flips and stray operands.
  function automatic request_t random_request();
    request_t r;
    int pick, next;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r = blank(CMD_SAMPLE);
      next = int'(trk_line) + $urandom_range(0, 60);
      if (next > int'(trk_vbl) + int'(trk_vbl) / 8 + 4 || next > 1023)
        next = $urandom_range(0, 20);
      r.line = LB'(next);
      if ($urandom_range(0, 99) < 3) begin
        trk_vbl = LB'($urandom_range(0, 1023));
        r.line = LB'($urandom_range(0, 1023));
      end
      r.vbl = trk_vbl;
      if ($urandom_range(0, 99) < 6) trk_fb = $urandom;
      r.fb = trk_fb;
    end else if (pick < 60) begin
      r = blank(CMD_BUDGET);
      r.norm = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      r.maxs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      r.spin = $urandom_range(0, 1);
    end else if (pick < 75) begin
      r = blank(CMD_MEASURE);
      r.sfrm = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                            : trk_frame - $urandom_range(0, 4);
      r.sline = ($urandom_range(0, 9) == 0) ? LB'($urandom_range(0, 1023))
                                             : LB'($urandom_range(0, trk_line));
      case ($urandom_range(0, 19))
        0:       r.scnt = 16'd0;
        1:       r.scnt = 16'($urandom);
        default: r.scnt = 16'($urandom_range(1, 64));
      endcase
      r.spin = $urandom_range(0, 1);
    end else if (pick < 87) begin
      r = blank(CMD_SPIN);
    end else if (pick < 97) begin
      r = blank(CMD_STAT);
      r.sidx = IDX_W'($urandom_range(0, 15));
    end else begin
      r = blank(CMD_W'($urandom_range(5, 7)));
      r.fb = $urandom;
    end
    return r;
  endfunction

  // Send a phase of random requests in bursts with idle gaps between them.
  task automatic random_phase(input int count, input bit hold_off);
    int burst, gap_max;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        go_idle();
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 30;
        repeat ($urandom_range(0, gap_max)) @(negedge clk);
        burst = $urandom_range(1, 40);
      end
      // ask for the long receiver hold mid-phase while requests keep coming
      if (hold_off && i == count / 2) hold_req = 1'b1;
      send_request(random_request());
      burst--;
    end
    drain();
  endtask

  initial begin
    request_t r;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_TRIAL; cfg_data = '0;
    in_valid = 1'b0; command = CMD_SAMPLE; scan_line = '0; vblank_line = '0;
    framebuffer = '0; normal_sectors = '0; max_sectors = '0; spin_mode = 1'b0;
    start_frame = '0; start_line = '0; sector_count = '0; stat_index = '0;
    trk_frame = 0; trk_line = '0; trk_vbl = '0; trk_fb = '0;
    hold_req = 1'b0; sent = 0;
    foreach (cmd_cnt[k]) cmd_cnt[k] = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: field extremes, every command, unknown commands, stat index
    // past the table, ignored and stale measures, untimed budget answers.
    r = blank(CMD_STAT); r.sidx = STAT_SLOT; send_request(r);
    r = blank(CMD_BUDGET); r.norm = '1; r.maxs = '1; r.spin = 1'b1; send_request(r);
    r = blank(CMD_SAMPLE); r.line = '1; r.vbl = '1; r.fb = '1; send_request(r);
    r = blank(CMD_SAMPLE); r.line = '0; r.vbl = '1; r.fb = '1; send_request(r);
    r = blank(CMD_SAMPLE); r.line = 10'd300; r.vbl = 10'd200; r.fb = '1; send_request(r);
    r = blank(CMD_SAMPLE); r.line = 10'd5; r.vbl = 10'd200; r.fb = '1; send_request(r);
    r = blank(CMD_SAMPLE); r.line = 10'd2; r.vbl = 10'd200; r.fb = '1; send_request(r);
    r = blank(CMD_MEASURE); r.scnt = '0; send_request(r);
    r = blank(CMD_MEASURE); r.sfrm = '1; r.sline = '1; r.scnt = '1; send_request(r);
    r = blank(CMD_MEASURE); r.sfrm = trk_frame - 1; r.sline = 10'd150; r.scnt = 16'd1;
    r.spin = 1'b1; send_request(r);
    r = blank(CMD_BUDGET); r.norm = '0; r.maxs = '1; send_request(r);
    r = blank(CMD_BUDGET); r.norm = 16'd7; r.maxs = '0; r.spin = 1'b1; send_request(r);
    r = blank(CMD_BUDGET); r.norm = '1; r.maxs = 16'd3; r.spin = 1'b1; send_request(r);
    r = blank(CMD_SAMPLE); r.fb = 32'h0000_1000; send_request(r);
    r = blank(CMD_SPIN); send_request(r);
    send_request(r);
    send_request(r);
    r = blank(CMD_STAT); r.sidx = STAT_SECTORS0; send_request(r);
    r = blank(CMD_STAT); r.sidx = STAT_CROSS; send_request(r);
    r = blank(CMD_STAT); r.sidx = IDX_W'(15); send_request(r);
    r = blank(CMD_STAT); r.sidx = IDX_W'(11); send_request(r);
    r = blank(3'd5); r.fb = 32'h5a5a_0000; send_request(r);
    r = blank(3'd7); r.line = '0; send_request(r);
    drain();

    // Random phases, register settings from the defaults to the extremes,
    // including zero thresholds and a dropped out-of-range index.
    random_phase(ITEMS_PER_PHASE, 1'b0);
    write_reg(CFG_TRIAL, 16'd1);
    write_reg(CFG_STILL, 16'd1);
    write_reg(CFG_SPIN, 16'd1);
    random_phase(ITEMS_PER_PHASE, 1'b1);
    write_reg(CFG_TRIAL, 16'hffff);
    write_reg(CFG_STILL, 16'h00ff);
    write_reg(CFG_SPIN, 16'hffff);
    random_phase(ITEMS_PER_PHASE, 1'b0);
    write_reg(CFG_TRIAL, 16'd3);
    write_reg(CFG_STILL, 16'd0);
    write_reg(CFG_SPIN, 16'd0);
    random_phase(ITEMS_PER_PHASE, 1'b1);
    write_reg(CFG_UNUSED, 16'h1234);
    write_reg(CFG_TRIAL, 16'd5);
    write_reg(CFG_STILL, 16'd4);
    write_reg(CFG_SPIN, 16'd2);
    random_phase(ITEMS_PER_PHASE, 1'b0);
    write_reg(CFG_TRIAL, 16'd0);
    write_reg(CFG_STILL, 16'd2);
    write_reg(CFG_SPIN, 16'd255);
    random_phase(ITEMS_PER_PHASE, 1'b0);

    $display("Run covered %0d requests: %0d sample, %0d budget, %0d measure, %0d spin,",
             sent, cmd_cnt[CMD_SAMPLE], cmd_cnt[CMD_BUDGET], cmd_cnt[CMD_MEASURE],
             cmd_cnt[CMD_SPIN]);
    $display("  %0d statistic, %0d unknown; %0d results compared over six settings.",
             cmd_cnt[CMD_STAT], cmd_cnt[5] + cmd_cnt[6] + cmd_cnt[7], checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
